// ===== rtl/core/lmrs_pkg.sv =====
// Package for the LED matrix row scanner: widths, defaults, codes and shared types.
`timescale 1ns / 1ps
package lmrs_pkg;

	localparam int VISIBLE_COLUMNS_DEF = 64;
	localparam int ROW_COUNT_DEF       = 16;
	localparam int STORE_COLUMNS_DEF   = 128;

	localparam int COMMAND_W     = 2;
	localparam int INDEX_W       = 7;
	localparam int DATA_W        = 16;
	localparam int ROW_W         = 4;
	localparam int COLUMN_BITS_W = 64;
	localparam int PERIOD_W      = 8;
	localparam int OFFSET_W      = 7;
	localparam int RED_W         = OFFSET_W + 1;

	localparam logic [PERIOD_W-1:0] SCROLL_PERIOD_RESET = 8'd50;

	typedef enum logic [COMMAND_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_START = 2'd2
	} command_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic tick_done;
	} scroll_event_t;

	typedef struct packed {
		logic [ROW_W-1:0]    row;
		logic [OFFSET_W-1:0] offset;
		logic                half;
		logic                ended_next;
		logic                half_next;
		logic                active_next;
	} scroll_status_t;

endpackage

// ===== rtl/core/lmrs_if.sv =====
// Channel interfaces: command request, row result and configuration write.
`timescale 1ns / 1ps
interface lmrs_req_if;
	import lmrs_pkg::*;
	logic                 valid;
	logic                 ready;
	command_t             command;
	logic [INDEX_W-1:0]   column_index;
	logic [DATA_W-1:0]    column_data;
	modport source (output valid, command, column_index, column_data, input ready);
	modport sink (input valid, command, column_index, column_data, output ready);
endinterface

interface lmrs_res_if;
	import lmrs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     row_data_bit;
	logic [ROW_W-1:0]         row_index;
	logic [COLUMN_BITS_W-1:0] column_bits;
	logic                     scroll_ended;
	logic                     half_select;
	logic                     scrolling;
	modport source (output valid, row_data_bit, row_index, column_bits, scroll_ended,
		half_select, scrolling, input ready);
	modport sink (input valid, row_data_bit, row_index, column_bits, scroll_ended,
		half_select, scrolling, output ready);
endinterface

interface lmrs_cfg_if;
	import lmrs_pkg::*;
	logic                valid;
	logic                ready;
	logic [PERIOD_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/lmrs_frame_store.sv =====
// Column store: synchronous two-port memory, per-entry valid bits cleared at reset.
`timescale 1ns / 1ps
module lmrs_frame_store #(
	parameter int STORE_COLUMNS = lmrs_pkg::STORE_COLUMNS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [$clog2(STORE_COLUMNS)-1:0]    wr_addr,
	input  logic [lmrs_pkg::DATA_W-1:0]         wr_data,
	input  logic                                rd_en,
	input  logic [$clog2(STORE_COLUMNS)-1:0]    rd_addr,
	output logic [lmrs_pkg::DATA_W-1:0]         rd_word
);
	import lmrs_pkg::*;

	logic [DATA_W-1:0]        mem [STORE_COLUMNS];
	logic [STORE_COLUMNS-1:0] valid_q;
	logic [DATA_W-1:0]        rdata_s1;
	logic                     rvalid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_word = rvalid_s1 ? rdata_s1 : '0;

endmodule

// ===== rtl/core/lmrs_scroll_ctrl.sv =====
// Scroll state: period register, row counter, start offset, half, speed and flags.
`timescale 1ns / 1ps
module lmrs_scroll_ctrl #(
	parameter int VISIBLE_COLUMNS = lmrs_pkg::VISIBLE_COLUMNS_DEF,
	parameter int ROW_COUNT       = lmrs_pkg::ROW_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lmrs_cfg_if.sink                 cfg,
	input  lmrs_pkg::scroll_event_t  ev,
	output lmrs_pkg::scroll_status_t status
);
	import lmrs_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [ROW_W-1:0]    row_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                half_q;
	logic [PERIOD_W-1:0] speed_q;
	logic                active_q;
	logic                ended_q;

	logic [PERIOD_W-1:0] speed_inc;
	logic                step;
	logic [PERIOD_W-1:0] speed_n;
	logic [OFFSET_W-1:0] offset_n;
	logic                wrap;
	logic [ROW_W:0]      row_inc;
	logic [ROW_W-1:0]    row_n;

	assign cfg.ready = 1'b1;

	always_comb begin
		speed_inc = speed_q + 1'b1;
		step      = speed_inc > period_q;
		speed_n   = step ? '0 : speed_inc;
		offset_n  = step ? offset_q + 1'b1 : offset_q;
		wrap      = active_q && (offset_n == OFFSET_W'(VISIBLE_COLUMNS)) && !ended_q;
		row_inc   = {1'b0, row_q} + 1'b1;
		row_n     = (row_inc >= (ROW_W+1)'(ROW_COUNT)) ? '0 : row_inc[ROW_W-1:0];

		status.row         = row_q;
		status.offset      = offset_q;
		status.half        = half_q;
		status.ended_next  = ended_q | wrap;
		status.half_next   = half_q ^ wrap;
		status.active_next = active_q & ~wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= SCROLL_PERIOD_RESET;
			row_q    <= '0;
			offset_q <= '0;
			half_q   <= 1'b0;
			speed_q  <= '0;
			active_q <= 1'b0;
			ended_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				period_q <= cfg.data;
			end
			if (ev.start) begin
				ended_q  <= 1'b0;
				active_q <= 1'b1;
			end
			if (ev.tick_done) begin
				row_q <= row_n;
				if (active_q) begin
					speed_q  <= speed_n;
					offset_q <= wrap ? '0 : offset_n;
					half_q   <= half_q ^ wrap;
					if (wrap) begin
						ended_q  <= 1'b1;
						active_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/lmrs_scan_seq.sv =====
// Command sequencer: index reduction, column read sweep, row assembly and result register.
`timescale 1ns / 1ps
module lmrs_scan_seq #(
	parameter int VISIBLE_COLUMNS = lmrs_pkg::VISIBLE_COLUMNS_DEF,
	parameter int STORE_COLUMNS   = lmrs_pkg::STORE_COLUMNS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	lmrs_req_if.sink                            request,
	lmrs_res_if.source                          result,
	input  lmrs_pkg::scroll_status_t            status,
	output lmrs_pkg::scroll_event_t             ev,
	output logic                                wr_en,
	output logic [$clog2(STORE_COLUMNS)-1:0]    wr_addr,
	output logic [lmrs_pkg::DATA_W-1:0]         wr_data,
	output logic                                rd_en,
	output logic [$clog2(STORE_COLUMNS)-1:0]    rd_addr,
	input  logic [lmrs_pkg::DATA_W-1:0]         rd_word
);
	import lmrs_pkg::*;

	localparam int AW = $clog2(STORE_COLUMNS);
	localparam int VG = ((VISIBLE_COLUMNS + 7) / 8) * 8;
	localparam int CW = $clog2(VG);
	localparam int KW = $clog2(COLUMN_BITS_W);

	seq_state_t               state_q, state_d;
	logic                     is_write_q;
	logic [RED_W-1:0]         red_q;
	logic [DATA_W-1:0]        data_q;
	logic [AW-1:0]            addr_q;
	logic [CW-1:0]            col_q;
	logic [CW-1:0]            col_s1;
	logic                     rd_s1;
	logic [COLUMN_BITS_W-1:0] bits_q;

	logic                     out_valid_q;
	logic                     out_row_bit_q;
	logic [ROW_W-1:0]         out_row_q;
	logic [COLUMN_BITS_W-1:0] out_bits_q;
	logic                     out_ended_q;
	logic                     out_half_q;
	logic                     out_active_q;

	logic                     accept;
	logic                     reduce_done;
	logic                     load_out;
	logic [RED_W-1:0]         base;
	logic [KW-1:0]            bit_k;

	assign reduce_done = red_q < RED_W'(STORE_COLUMNS);
	assign accept      = request.valid && request.ready;
	assign base        = {1'b0, status.offset} + (status.half ? RED_W'(VISIBLE_COLUMNS) : '0);
	assign bit_k       = KW'(col_s1 ^ CW'(7));

	always_comb begin
		state_d       = state_q;
		request.ready = 1'b0;
		ev            = '0;
		wr_en         = 1'b0;
		rd_en         = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				request.ready = 1'b1;
				if (request.valid) begin
					case (request.command)
						CMD_TICK:  state_d  = ST_REDUCE;
						CMD_WRITE: state_d  = ST_REDUCE;
						CMD_START: ev.start = 1'b1;
						default:   state_d  = ST_IDLE;
					endcase
				end
			end
			ST_REDUCE: begin
				if (reduce_done) begin
					if (is_write_q) begin
						wr_en   = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				rd_en = 1'b1;
				if (col_q == CW'(VG - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					load_out     = 1'b1;
					ev.tick_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= rd_en;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_write_q <= (request.command == CMD_WRITE);
			red_q      <= (request.command == CMD_WRITE) ? RED_W'(request.column_index) : base;
			data_q     <= request.column_data;
			bits_q     <= '1;
		end
		if (state_q == ST_REDUCE) begin
			if (reduce_done) begin
				addr_q <= red_q[AW-1:0];
				col_q  <= '0;
			end else begin
				red_q <= red_q - RED_W'(STORE_COLUMNS);
			end
		end
		if (state_q == ST_READ) begin
			col_q  <= col_q + 1'b1;
			addr_q <= (addr_q == AW'(STORE_COLUMNS - 1)) ? '0 : addr_q + 1'b1;
		end
		col_s1 <= col_q;
		if (rd_s1 && ({1'b0, bit_k} < (KW+1)'(VISIBLE_COLUMNS))) begin
			bits_q[bit_k] <= ~rd_word[status.row];
		end
		if (load_out) begin
			out_row_bit_q <= (status.row != '0);
			out_row_q     <= status.row;
			out_bits_q    <= bits_q;
			out_ended_q   <= status.ended_next;
			out_half_q    <= status.half_next;
			out_active_q  <= status.active_next;
		end
	end

	assign wr_addr = red_q[AW-1:0];
	assign wr_data = data_q;
	assign rd_addr = addr_q;

	assign result.valid        = out_valid_q;
	assign result.row_data_bit = out_row_bit_q;
	assign result.row_index    = out_row_q;
	assign result.column_bits  = out_bits_q;
	assign result.scroll_ended = out_ended_q;
	assign result.half_select  = out_half_q;
	assign result.scrolling    = out_active_q;

endmodule

// ===== rtl/core/led_matrix_row_scan_scroll_core.sv =====
// Top level of the LED matrix row scanner and scroller.
//
// request carries one command item: scan tick, write column or start scrolling.
// result carries one row item per scan tick; writes and starts give no result.
// cfg writes the scroll period (ticks minus one between single-column steps).
//
// A write item is accepted, the store size is subtracted from the index while it is
// out of range, and then the column memory is written.
// A tick is accepted, the store size is subtracted from the read base while it is out
// of range, and VISIBLE_COLUMNS (rounded up to a multiple of 8) columns are read from
// the column memory one column per cycle. A start item only raises the start event.
// The result register parts the two sides: the next item is accepted while a row
// waits to be taken. A tick whose row is done waits while the receiver stalls.
// Reset clears the column store valid bits at once, so every column reads as
// unlit, and sets the scroll period to 50 with scrolling stopped.
`timescale 1ns / 1ps
module led_matrix_row_scan_scroll_core #(
	parameter int VISIBLE_COLUMNS = lmrs_pkg::VISIBLE_COLUMNS_DEF,
	parameter int ROW_COUNT       = lmrs_pkg::ROW_COUNT_DEF,
	parameter int STORE_COLUMNS   = lmrs_pkg::STORE_COLUMNS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lmrs_req_if.sink   request,
	lmrs_res_if.source result,
	lmrs_cfg_if.sink   cfg
);
	import lmrs_pkg::*;

	localparam int AW = $clog2(STORE_COLUMNS);

	scroll_event_t     ev;
	scroll_status_t    status;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_word;

	lmrs_scroll_ctrl #(
		.VISIBLE_COLUMNS(VISIBLE_COLUMNS),
		.ROW_COUNT(ROW_COUNT)
	) u_scroll_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.ev(ev),
		.status(status)
	);

	lmrs_frame_store #(
		.STORE_COLUMNS(STORE_COLUMNS)
	) u_frame_store (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_word(rd_word)
	);

	lmrs_scan_seq #(
		.VISIBLE_COLUMNS(VISIBLE_COLUMNS),
		.STORE_COLUMNS(STORE_COLUMNS)
	) u_scan_seq (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.result(result),
		.status(status),
		.ev(ev),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_word(rd_word)
	);

endmodule

// ===== rtl/core/lmrs_checker.sv =====
// Port-level checker for the row scanner and its bind to the top level.
`timescale 1ns / 1ps
module lmrs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       res_row_data_bit,
	input logic [lmrs_pkg::ROW_W-1:0] res_row_index,
	input logic                       res_scroll_ended,
	input logic                       res_scrolling
);
	import lmrs_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	a_row_select: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_row_data_bit == (res_row_index != '0)))
		else $error("row select bit does not match row index");

	a_ended_stops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_scroll_ended && res_scrolling))
		else $error("scroll ended while still scrolling");

endmodule

bind led_matrix_row_scan_scroll_core lmrs_checker u_lmrs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_row_data_bit(result.row_data_bit),
	.res_row_index(result.row_index),
	.res_scroll_ended(result.scroll_ended),
	.res_scrolling(result.scrolling)
);

// ===== verif/led_matrix_row_scan_scroll_core_test.sv =====
// Self-checking testbench for the LED matrix row scanner and scroller core.
`timescale 1ns / 1ps
module led_matrix_row_scan_scroll_core_test;
	import lmrs_pkg::*;

	localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;
	localparam int LONG_STALL_CYCLES = 2000;
	localparam int ITEMS_PER_PHASE   = 220;
	localparam int MAX_REPORTS       = 10;

	typedef struct packed {
		logic                     row_data_bit;
		logic [ROW_W-1:0]         row_index;
		logic [COLUMN_BITS_W-1:0] column_bits;
		logic                     scroll_ended;
		logic                     half_select;
		logic                     scrolling;
	} row_item_t;

	typedef struct {
		logic [COMMAND_W-1:0] command;
		logic [INDEX_W-1:0]   column_index;
		logic [DATA_W-1:0]    column_data;
		bit                   typed;
		row_item_t            want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	lmrs_req_if request_ch();
	lmrs_res_if result_ch();
	lmrs_cfg_if cfg_ch();

	led_matrix_row_scan_scroll_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic [DATA_W-1:0]   column_store [STORE_COLUMNS_DEF];
	logic [ROW_W-1:0]    row_ctr;
	logic [OFFSET_W-1:0] offset;
	logic                half_sel;
	logic                active;
	logic                ended;
	logic [PERIOD_W-1:0] speed_ctr;
	logic [PERIOD_W-1:0] period;

	row_item_t row_queue [$];
	plan_row_t directed [$];
	int        error_count = 0;
	int        rows_taken = 0;
	bit        fast_sender = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.command = CMD_TICK;
		request_ch.column_index = '0;
		request_ch.column_data = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = SCROLL_PERIOD_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#12_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Predict one row and advance the row counter and the scroll state.
	function automatic row_item_t predict_row();
		row_item_t item;
		int        base;
		int        col;
		base = int'(offset) + (half_sel ? VISIBLE_COLUMNS_DEF : 0);
		item.row_data_bit = (row_ctr != '0);
		item.row_index = row_ctr;
		item.column_bits = '1;
		for (int k = 0; k < VISIBLE_COLUMNS_DEF; k++) begin
			col = (base + (k / 8) * 8 + 7 - k % 8) % STORE_COLUMNS_DEF;
			if (column_store[col][row_ctr])
				item.column_bits[k] = 1'b0;
		end
		row_ctr = row_ctr + 1'b1;
		if (active) begin
			speed_ctr = speed_ctr + 1'b1;
			if (speed_ctr > period) begin
				speed_ctr = '0;
				offset = offset + 1'b1;
			end
			if (offset == OFFSET_W'(VISIBLE_COLUMNS_DEF) && !ended) begin
				offset = '0;
				half_sel = ~half_sel;
				ended = 1'b1;
				active = 1'b0;
			end
		end
		item.scroll_ended = ended;
		item.half_select = half_sel;
		item.scrolling = active;
		return item;
	endfunction

	task automatic flag_row(input string what, input row_item_t want, input row_item_t got);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("%s at %0t: want rdb %b row %0d cols %h ended %b half %b scroll %b",
				what, $realtime, want.row_data_bit, want.row_index, want.column_bits,
				want.scroll_ended, want.half_select, want.scrolling);
			$display("    got rdb %b row %0d cols %h ended %b half %b scroll %b",
				got.row_data_bit, got.row_index, got.column_bits,
				got.scroll_ended, got.half_select, got.scrolling);
		end
	endtask

	task automatic plan(input logic [COMMAND_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
		input logic [DATA_W-1:0] data, input bit typed, input row_item_t want);
		plan_row_t r;
		r.command = cmd;
		r.column_index = idx;
		r.column_data = data;
		r.typed = typed;
		r.want = want;
		directed.push_back(r);
	endtask

	task automatic offer_item(input logic [COMMAND_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
		input logic [DATA_W-1:0] data, input bit typed, input row_item_t want);
		row_item_t predicted;
		int        gap;
		@(negedge clk);
		request_ch.valid <= 1'b1;
		request_ch.command <= command_t'(cmd);
		request_ch.column_index <= idx;
		request_ch.column_data <= data;
		@(posedge clk);
		while (!request_ch.ready)
			@(posedge clk);
		case (cmd)
			CMD_TICK: begin
				predicted = predict_row();
				row_queue.push_back(typed ? want : predicted);
			end
			CMD_WRITE: column_store[idx] = data;
			CMD_START: begin
				ended = 1'b0;
				active = 1'b1;
			end
			default: ;
		endcase
		gap = fast_sender ? 0 : idle_length();
		if (gap > 0) begin
			@(negedge clk);
			request_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Hold off new items until every row is back, then wait extra more clocks.
	task automatic settle(input int extra);
		@(negedge clk);
		request_ch.valid <= 1'b0;
		while (row_queue.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		period = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : receiver
		int stall_left;
		bit steady;
		bit long_stall_done;
		stall_left = 0;
		steady = 1'b0;
		long_stall_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!long_stall_done && rows_taken >= 100) begin
				long_stall_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (LONG_STALL_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 299) == 0)
				steady = ~steady;
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if (!steady)
					stall_left = idle_length();
			end
		end
	end

	always @(posedge clk) begin : row_checker
		row_item_t got;
		row_item_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.row_data_bit = result_ch.row_data_bit;
			got.row_index = result_ch.row_index;
			got.column_bits = result_ch.column_bits;
			got.scroll_ended = result_ch.scroll_ended;
			got.half_select = result_ch.half_select;
			got.scrolling = result_ch.scrolling;
			rows_taken++;
			if (row_queue.size() == 0) begin
				flag_row("unexpected row item", '0, got);
			end else begin
				want = row_queue.pop_front();
				if (got !== want)
					flag_row("row item mismatch", want, got);
			end
		end
	end

	initial begin : stimulus
		row_item_t none;
		row_item_t first_row;
		row_item_t second_row;
		int        periods [7];
		int        counted;
		int        r;
		logic [DATA_W-1:0] data;

		foreach (column_store[i])
			column_store[i] = '0;
		row_ctr = '0;
		offset = '0;
		half_sel = 1'b0;
		active = 1'b0;
		ended = 1'b0;
		speed_ctr = '0;
		period = SCROLL_PERIOD_RESET;

		none = '0;
		first_row = '0;
		first_row.column_bits = '1;
		second_row = first_row;
		second_row.row_data_bit = 1'b1;
		second_row.row_index = 4'd1;

		plan(CMD_TICK, 7'd0, 16'h0000, 1'b1, first_row);
		plan(CMD_TICK, 7'd127, 16'hFFFF, 1'b1, second_row);
		plan(CMD_WRITE, 7'd0, 16'hFFFF, 1'b0, none);
		plan(CMD_WRITE, 7'd127, 16'hFFFF, 1'b0, none);
		plan(CMD_WRITE, 7'd7, 16'h0001, 1'b0, none);
		plan(CMD_WRITE, 7'd64, 16'h8000, 1'b0, none);
		plan(CMD_WRITE, 7'd63, 16'hAAAA, 1'b0, none);
		plan(CMD_UNUSED, 7'd127, 16'hFFFF, 1'b0, none);
		plan(CMD_TICK, 7'd0, 16'h0000, 1'b0, none);
		plan(CMD_START, 7'd0, 16'h0000, 1'b0, none);
		plan(CMD_TICK, 7'd0, 16'h0000, 1'b0, none);
		plan(CMD_START, 7'd127, 16'hFFFF, 1'b0, none);
		for (int i = 0; i < 13; i++)
			plan(CMD_TICK, 7'(i), 16'h0000, 1'b0, none);

		wait (arst_n === 1'b1);
		foreach (directed[i])
			offer_item(directed[i].command, directed[i].column_index,
				directed[i].column_data, directed[i].typed, directed[i].want);
		settle(20);

		periods = '{255, 0, 1, 0, 3, 2, 0};
		periods[3] = $urandom_range(0, 255);
		foreach (periods[p]) begin
			write_period(PERIOD_W'(periods[p]));
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				if (counted % 64 == 0)
					fast_sender = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				case ($urandom_range(0, 7))
					0: data = '0;
					1: data = '1;
					default: data = DATA_W'($urandom);
				endcase
				if (r < 66) begin
					offer_item(CMD_TICK, INDEX_W'($urandom), data, 1'b0, none);
					counted++;
				end else if (r < 92) begin
					offer_item(CMD_WRITE, INDEX_W'($urandom), data, 1'b0, none);
					counted++;
				end else if (r < 97) begin
					offer_item(CMD_START, INDEX_W'($urandom), data, 1'b0, none);
					counted++;
				end else begin
					offer_item(CMD_UNUSED, INDEX_W'($urandom), data, 1'b0, none);
				end
			end
			fast_sender = 1'b0;
			settle(20);
		end

		settle(100);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lmrs_pkg.sv
rtl/core/lmrs_if.sv
rtl/core/lmrs_frame_store.sv
rtl/core/lmrs_scroll_ctrl.sv
rtl/core/lmrs_scan_seq.sv
rtl/core/led_matrix_row_scan_scroll_core.sv
rtl/core/lmrs_checker.sv
verif/led_matrix_row_scan_scroll_core_test.sv
